### sv/ctc_pkg.sv
package ctc_pkg;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   localparam logic [6:0] SECS_PER_MIN  = 7'd60;
   localparam logic [6:0] MINS_PER_HOUR = 7'd60;
   localparam logic [5:0] HOURS_PER_DAY = 6'd24;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_AUG = 4'd8;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] DAYS_31      = 5'd31;
   localparam logic [4:0] DAYS_30      = 5'd30;
   localparam logic [4:0] DAYS_29      = 5'd29;
   localparam logic [4:0] DAYS_28      = 5'd28;
   localparam logic [4:0] FIRST_DAY    = 5'd1;

   // divisibility by 25: y * inverse(25) mod 2^16 lands at or below (2^16-1)/25
   localparam logic [15:0] INV25       = 16'd23593;
   localparam logic [15:0] DIV25_LIMIT = 16'd2621;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } hms_type;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   typedef struct packed {
      date_type date;
      hms_type  hms;
   } time_type;

   localparam time_type RESET_TIME = '{
      date: '{year: 16'd2012, month: 4'd1, day: 5'd1},
      hms:  '{hour: 5'd1, minute: 6'd0, second: 6'd5}
   };

endpackage

### sv/calendar_time_counter.sv
// Calendar clock: keeps second, minute, hour, day, month and year. A tick beat
// (req_tuser = 0) adds add_seconds with carry up through the Gregorian
// calendar; a load beat (req_tuser = 1) overwrites every field. Each beat
// returns one result beat with the time after it, plus a flag on rsp_tuser
// when a tick rolled into a new day. One beat is taken per clock while no
// held result stalls; the input register feeds the seconds to hours carry
// chain, the day/month step and the leap-year multiply into the state register.
module calendar_time_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // add_seconds[5:0], load_second[11:6], load_minute[17:12], load_hour[22:18],
   // load_day[27:23], load_month[31:28], load_year[47:32]
   input  logic [47:0] req_tdata,
   // kind[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // second_now[5:0], minute_now[11:6], hour_now[16:12], day_now[21:17],
   // month_now[25:22], year_now[41:26], zero[47:42]
   output logic [47:0] rsp_tdata,
   // day_advanced[0]
   output logic [0:0]  rsp_tuser
);

   logic              in_valid_ff, in_valid_in;
   logic              in_kind_ff;
   logic [47:0]       in_data_ff;
   logic              out_valid_ff, out_valid_in;
   logic              day_adv_ff, day_adv_in;
   ctc_pkg::time_type state_ff, state_in;

   logic              advance;
   logic              take;
   logic [5:0]        add_seconds;
   ctc_pkg::time_type load_time;
   ctc_pkg::hms_type  hms_nxt;
   ctc_pkg::date_type date_nxt;
   logic              day_carry;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign add_seconds           = in_data_ff[5:0];
   assign load_time.hms.second  = in_data_ff[11:6];
   assign load_time.hms.minute  = in_data_ff[17:12];
   assign load_time.hms.hour    = in_data_ff[22:18];
   assign load_time.date.day    = in_data_ff[27:23];
   assign load_time.date.month  = in_data_ff[31:28];
   assign load_time.date.year   = in_data_ff[47:32];

   ctc_time_carry u_time_carry (
      .cur         (state_ff.hms),
      .add_seconds (add_seconds),
      .nxt         (hms_nxt),
      .day_carry   (day_carry)
   );

   ctc_date_step u_date_step (
      .cur  (state_ff.date),
      .step (day_carry),
      .nxt  (date_nxt)
   );

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      state_in     = state_ff;
      day_adv_in   = day_adv_ff;
      if (advance && in_valid_ff) begin
         if (in_kind_ff == ctc_pkg::KIND_LOAD) begin
            state_in   = load_time;
            day_adv_in = 1'b0;
         end else begin
            state_in   = '{date: date_nxt, hms: hms_nxt};
            day_adv_in = day_carry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ctc_pkg::RESET_TIME;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_kind_ff <= req_tuser[0];
         in_data_ff <= req_tdata;
      end
      day_adv_ff <= day_adv_in;
   end

   // result payload is the live state: it moves only when the output may advance
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, state_ff.date.year, state_ff.date.month, state_ff.date.day,
                        state_ff.hms.hour, state_ff.hms.minute, state_ff.hms.second};
   assign rsp_tuser  = day_adv_ff;

   a_reset_time: assert property (@(posedge clock)
      reset |=> (state_ff == ctc_pkg::RESET_TIME) && !rsp_tvalid && !in_valid_ff)
      else $error("state not at reset time after reset");

   a_load_copies: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && in_kind_ff == ctc_pkg::KIND_LOAD)
      |=> (state_ff == $past(load_time)) && !day_adv_ff)
      else $error("load beat did not copy fields");

   a_day_wrap_small: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0])
      |-> (state_ff.hms.hour < 5'd9) && (state_ff.hms.minute < 6'd6))
      else $error("day advance with implausible hour or minute");

   a_day_adv_tick_only: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff) |=> (day_adv_ff == ($past(in_kind_ff) == ctc_pkg::KIND_TICK
                                                  && $past(day_carry))))
      else $error("day advance flag mismatch");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !(advance && in_valid_ff) |=> $stable(state_ff))
      else $error("state changed without a beat");

endmodule

### sv/ctc_time_carry.sv
module ctc_time_carry (
   input  ctc_pkg::hms_type cur,
   input  logic [5:0]       add_seconds,
   output ctc_pkg::hms_type nxt,
   output logic             day_carry
);

   logic [6:0] sec_sum;
   logic [1:0] min_inc;
   logic [6:0] sec_left;
   logic [6:0] min_sum;
   logic       hour_carry;
   logic [6:0] min_left;
   logic [5:0] hour_sum;
   logic [5:0] hour_left;

   always_comb begin
      sec_sum = {1'b0, cur.second} + {1'b0, add_seconds};
      if (sec_sum >= 7'(2 * ctc_pkg::SECS_PER_MIN)) begin
         min_inc  = 2'd2;
         sec_left = sec_sum - 7'(2 * ctc_pkg::SECS_PER_MIN);
      end else if (sec_sum >= ctc_pkg::SECS_PER_MIN) begin
         min_inc  = 2'd1;
         sec_left = sec_sum - ctc_pkg::SECS_PER_MIN;
      end else begin
         min_inc  = 2'd0;
         sec_left = sec_sum;
      end

      // a loaded minute of 60..63 stays put until a carry arrives from below
      min_sum    = {1'b0, cur.minute} + {5'd0, min_inc};
      hour_carry = (min_inc != 2'd0) && (min_sum >= ctc_pkg::MINS_PER_HOUR);
      min_left   = hour_carry ? (min_sum - ctc_pkg::MINS_PER_HOUR) : min_sum;

      hour_sum   = {1'b0, cur.hour} + {5'd0, hour_carry};
      day_carry  = hour_carry && (hour_sum >= ctc_pkg::HOURS_PER_DAY);
      hour_left  = day_carry ? (hour_sum - ctc_pkg::HOURS_PER_DAY) : hour_sum;

      nxt.second = sec_left[5:0];
      nxt.minute = min_left[5:0];
      nxt.hour   = hour_left[4:0];
   end

endmodule

### sv/ctc_date_step.sv
module ctc_date_step (
   input  ctc_pkg::date_type cur,
   input  logic              step,
   output ctc_pkg::date_type nxt
);

   logic [15:0] year_scaled;
   logic        div4;
   logic        div16;
   logic        div25;
   logic        leap;
   logic [4:0]  month_len;

   assign year_scaled = cur.year * ctc_pkg::INV25;

   always_comb begin
      div4  = (cur.year[1:0] == 2'd0);
      div16 = (cur.year[3:0] == 4'd0);
      div25 = (year_scaled <= ctc_pkg::DIV25_LIMIT);
      // century years leap only when also divisible by 400, i.e. by 16 as well
      leap  = div4 && (!div25 || div16);

      if (cur.month == ctc_pkg::MONTH_FEB) begin
         month_len = leap ? ctc_pkg::DAYS_29 : ctc_pkg::DAYS_28;
      end else if (cur.month < ctc_pkg::MONTH_AUG) begin
         month_len = cur.month[0] ? ctc_pkg::DAYS_31 : ctc_pkg::DAYS_30;
      end else begin
         month_len = cur.month[0] ? ctc_pkg::DAYS_30 : ctc_pkg::DAYS_31;
      end

      nxt = cur;
      if (step) begin
         if (cur.day < month_len) begin
            nxt.day = cur.day + 5'd1;
         end else begin
            nxt.day = ctc_pkg::FIRST_DAY;
            if (cur.month < ctc_pkg::MONTH_DEC) begin
               nxt.month = cur.month + 4'd1;
            end else begin
               nxt.month = ctc_pkg::MONTH_JAN;
               nxt.year  = cur.year + 16'd1;
            end
         end
      end
   end

endmodule
